[design/ktls_pkg.sv]
package ktls_pkg;

  // Operation codes carried by the action field
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_REMOVE  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;
  localparam logic [1:0] ACT_LOOKUP  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Result field widths
  localparam int unsigned IDX_OUT_W = 5;
  localparam int unsigned VAL_W     = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic start;  // latch the incoming transaction, restart the read pipe
    logic scan;   // run the key search
    logic apply;  // search finished: perform the operation
    logic shift;  // compact the table after a removal
    logic dec;    // removal finished: drop one entry
    logic load;   // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;         // compared entry matches the key
    logic drained;     // no read in flight and nothing left to read
    logic need_shift;  // hit on a removal
  } dp_stat_t;

endpackage

[design/ktls_datapath.sv]
module ktls_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ktls_pkg::dp_cmd_t  cmd,
  output ktls_pkg::dp_stat_t stat,
  input  logic [1:0]         action,
  input  logic signed [31:0] key,
  input  logic [31:0]        value,
  output logic [1:0]         status,
  output logic [31:0]        found_value,
  output logic [4:0]         found_index,
  output logic [4:0]         entry_total
);
  import ktls_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Table storage
  logic [31:0] key_mem [DEPTH];
  logic [31:0] val_mem [DEPTH];

  // Latched transaction
  logic [1:0]  action_q;
  logic [31:0] key_q;
  logic [31:0] value_q;

  // Read pipeline
  logic [CNT_W-1:0] issue_ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_key;
  logic [31:0]      rd_val;
  logic             rd_issue;

  // Operation state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  logic [1:0]       res_status;
  logic [31:0]      res_value;
  logic             full;

  // Memory write ports
  logic             key_we;
  logic [IDX_W-1:0] key_wa;
  logic [31:0]      key_wd;
  logic             val_we;
  logic [IDX_W-1:0] val_wa;
  logic [31:0]      val_wd;

  logic [31:0] pos_ext;
  logic [31:0] count_ext;

  // Status back to the controller
  assign stat.hit        = rd_vld && (rd_key == key_q);
  assign stat.drained    = !rd_vld && (issue_ptr >= count);
  assign stat.need_shift = (action_q == ACT_REMOVE) && stat.hit;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_issue = ((cmd.scan && !cmd.apply) || cmd.shift) && (issue_ptr < count);

  // Write port selection: insert, replace or compaction move
  always_comb begin
    key_we = 1'b0;
    key_wa = rd_idx - IDX_W'(1);
    key_wd = rd_key;
    val_we = 1'b0;
    val_wa = rd_idx - IDX_W'(1);
    val_wd = rd_val;
    if (cmd.apply) begin
      if (action_q == ACT_INSERT && !stat.hit && !full) begin
        key_we = 1'b1;
        key_wa = count[IDX_W-1:0];
        key_wd = key_q;
        val_we = 1'b1;
        val_wa = count[IDX_W-1:0];
        val_wd = value_q;
      end else if (action_q == ACT_REPLACE && stat.hit) begin
        val_we = 1'b1;
        val_wa = rd_idx;
        val_wd = value_q;
      end
    end else if (cmd.shift && rd_vld) begin
      key_we = 1'b1;
      val_we = 1'b1;
    end
  end

  // Key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (rd_issue) begin
      rd_key <= key_mem[issue_ptr[IDX_W-1:0]];
    end
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (rd_issue) begin
      rd_val <= val_mem[issue_ptr[IDX_W-1:0]];
    end
  end

  // Transaction latch
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_q <= action;
      key_q    <= key;
      value_q  <= value;
    end
  end

  // Read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      issue_ptr <= '0;
    end else if (cmd.start) begin
      rd_vld    <= 1'b0;
      issue_ptr <= '0;
    end else if (cmd.apply) begin
      rd_vld    <= 1'b0;
      issue_ptr <= CNT_W'(rd_idx) + CNT_W'(1);
    end else if (cmd.scan || cmd.shift) begin
      rd_vld <= rd_issue;
      if (rd_issue) begin
        issue_ptr <= issue_ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_idx <= issue_ptr[IDX_W-1:0];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply && action_q == ACT_INSERT && !stat.hit && !full) begin
      count <= count + CNT_W'(1);
    end else if (cmd.dec) begin
      count <= count - CNT_W'(1);
    end
  end

  // Operation outcome
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_value <= (stat.hit && action_q == ACT_LOOKUP) ? rd_val : '0;
      if (stat.hit) begin
        res_status <= (action_q == ACT_INSERT) ? ST_MISS : ST_DONE;
        pos        <= CNT_W'(rd_idx);
      end else begin
        case (action_q)
          ACT_INSERT: begin
            if (full) begin
              res_status <= ST_FULL;
              pos        <= CNT_W'(DEPTH);
            end else begin
              res_status <= ST_DONE;
              pos        <= count;
            end
          end
          default: begin
            res_status <= ST_MISS;
            pos        <= CNT_W'(DEPTH);
          end
        endcase
      end
    end
  end

  // Output register
  assign pos_ext   = 32'(pos);
  assign count_ext = 32'(count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= res_status;
      found_value <= res_value;
      found_index <= pos_ext[IDX_OUT_W-1:0];
      entry_total <= count_ext[IDX_OUT_W-1:0];
    end
  end

endmodule

[design/ktls_ctrl.sv]
module ktls_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ktls_pkg::dp_cmd_t  cmd,
  input  ktls_pkg::dp_stat_t stat
);
  import ktls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Sequencing of one transaction
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.drained) begin
          cmd.apply  = 1'b1;
          state_next = stat.need_shift ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.drained) begin
          cmd.dec    = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[design/keyed_table_linear_search_core.sv]
// Keyed table with linear search: up to DEPTH key/value pairs kept in
// insertion order. Each input transaction (action, key, value) inserts,
// removes, replaces a value or looks up a key, and yields exactly one
// result transaction (status, found_value, found_index, entry_total).
// Both channels use valid/ready; a transaction moves when both are high.
// The search reads one entry per cycle from the key/value memories
// through a registered read port and stops at the first match. A
// removal then moves every later entry down one place, one per cycle.
// The input handoff takes place in the idle state and the result load
// in the done state. One transaction is worked on at a time.
// The result sits in an output register; the next transaction is
// accepted while it waits. A receiver stall holds the finished result of
// the following transaction inside the block until the register frees.
// Reset empties the table (entry count zero); the memories are not cleared.
module keyed_table_linear_search_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] key,
  input  logic [31:0]        value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [31:0]        found_value,
  output logic [4:0]         found_index,
  output logic [4:0]         entry_total
);
  import ktls_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller
  ktls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Table storage, search and result datapath
  ktls_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .key         (key),
    .value       (value),
    .status      (status),
    .found_value (found_value),
    .found_index (found_index),
    .entry_total (entry_total)
  );

endmodule
